// ===== sv/assert_macros.svh =====
// shared assertion macros for the evaluator checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

// ===== sv/mpe_pkg.sv =====
package mpe_pkg;

   localparam int DATA_W    = 32;
   localparam int MAX_COEFS = 4096;
   localparam int ADDR_W    = $clog2(MAX_COEFS);
   localparam int COUNT_W   = $clog2(MAX_COEFS + 1);

   // one multiplier bit per cycle in the modular multiplier
   localparam int MUL_STEPS = DATA_W;
   localparam int STEP_W    = $clog2(MUL_STEPS);

   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   typedef logic [DATA_W-1:0]  data_type;
   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

// ===== sv/mpe_ram.sv =====
module mpe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/mpe_mulmod.sv =====
module mpe_mulmod (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  mpe_pkg::data_type a,
   input  mpe_pkg::data_type b,
   input  mpe_pkg::data_type modulus,
   output mpe_pkg::data_type result,
   output logic             done
);

   import mpe_pkg::*;

   // a must be below modulus, b may be any value
   data_type          a_ff, a_in;
   data_type          b_ff, b_in;
   data_type          r_ff, r_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DATA_W+1:0] t;
   logic [DATA_W+1:0] m1;
   logic [DATA_W+1:0] m2;

   assign m1 = {2'b00, modulus};
   assign m2 = {1'b0, modulus, 1'b0};

   // r = 2r + bit*a, below 3m, brought back under m
   always_comb begin
      t = {1'b0, r_ff, 1'b0} + (b_ff[DATA_W-1] ? {2'b00, a_ff} : '0);
   end

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         r_in    = '0;
         cnt_in  = STEP_W'(MUL_STEPS - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         priority if (t >= m2) begin
            r_in = DATA_W'(t - m2);
         end else if (t >= m1) begin
            r_in = DATA_W'(t - m1);
         end else begin
            r_in = DATA_W'(t);
         end
         b_in = {b_ff[DATA_W-2:0], 1'b0};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign result = r_ff;
   assign done   = done_ff;

endmodule

// ===== sv/modular_polynomial_evaluator.sv =====
// modular polynomial evaluator
//
// request channel (req_valid / req_ready): req_type selects a load or an
// evaluate. a load stores req_coefficient as the next coefficient, with
// req_restart_table emptying the table first; loads past the table depth
// without restart are dropped. a load leaves req_ready high and gives no response.
// an evaluate returns on the response channel (rsp_valid / rsp_ready) the
// sum of coef[j] * req_point^j modulo the csr modulus.
// an evaluate works through the stored coefficients one after another:
// each coefficient costs one read of the coefficient memory and 32 steps of
// the bit-serial modular multipliers (product and next power run side by
// side), then one accumulate step. an empty table or a modulus of 0 or 1
// answers 0 straight from the done state. one request is in work at a time.
// reset clears the coefficient count and sets the modulus to 1; the memory
// itself is not cleared. a stalled response sits in the output register;
// loads are still taken meanwhile, and a finished evaluate waits for it.
// the modulus is written through csr_write_enable / csr_write_data and may
// only change while no evaluate is pending.
module modular_polynomial_evaluator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic              req_restart_table,
   input  mpe_pkg::data_type req_coefficient,
   input  mpe_pkg::data_type req_point,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mpe_pkg::data_type rsp_poly_value,
   input  logic              csr_write_enable,
   input  mpe_pkg::data_type csr_write_data
);

   import mpe_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_LATCH = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_ACC   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff, state_in;
   data_type   modulus_ff, modulus_in;
   count_type  count_ff, count_in;
   count_type  idx_ff, idx_in;     // coefficient being worked on
   data_type   point_ff, point_in;
   data_type   acc_ff, acc_in;     // running sum, kept below modulus
   data_type   pow_ff, pow_in;     // point^idx, kept below modulus
   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_value_ff, rsp_value_in;

   // coefficient memory ports
   logic       wr_en;
   addr_type   wr_addr;
   addr_type   rd_addr;
   data_type   rd_coef;

   // multiplier hookup
   logic       mul_start;
   data_type   prod_term;
   data_type   prod_pow;
   logic       term_done;
   logic       pow_done;

   logic                req_fire;
   logic                rsp_fire;
   logic                trivial;
   logic [DATA_W:0]     sum;
   data_type            sum_red;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   // modulus 0 or 1, or no coefficients: the answer is 0
   assign trivial = (modulus_ff <= DATA_W'(1)) || (count_ff == '0);

   // acc + term, both below modulus, so one subtract brings it back
   assign sum     = {1'b0, acc_ff} + {1'b0, prod_term};
   assign sum_red = (sum >= {1'b0, modulus_ff}) ? DATA_W'(sum - {1'b0, modulus_ff})
                                                : DATA_W'(sum);

   assign modulus_in = csr_write_enable ? csr_write_data : modulus_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      point_in     = point_ff;
      acc_in       = acc_ff;
      pow_in       = pow_ff;
      rsp_valid_in = rsp_fire ? 1'b0 : rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      wr_en        = 1'b0;
      wr_addr      = count_ff[ADDR_W-1:0];
      rd_addr      = '0;
      mul_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_type == REQ_LOAD) begin
                  // restart writes slot 0, otherwise append while room is left
                  if (req_restart_table) begin
                     wr_en    = 1'b1;
                     wr_addr  = '0;
                     count_in = COUNT_W'(1);
                  end else if (count_ff < COUNT_W'(MAX_COEFS)) begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                  end
               end else begin
                  point_in = req_point;
                  idx_in   = '0;
                  acc_in   = '0;
                  pow_in   = DATA_W'(1);
                  state_in = trivial ? S_DONE : S_LATCH;
               end
            end
         end
         S_LATCH: begin
            // coefficient read is back, kick off both products
            mul_start = 1'b1;
            state_in  = S_MUL;
         end
         S_MUL: begin
            // both products finish in the same cycle
            if (term_done && pow_done) begin
               state_in = S_ACC;
            end
         end
         S_ACC: begin
            acc_in  = sum_red;
            pow_in  = prod_pow;
            idx_in  = idx_ff + 1'b1;
            // prefetch the next coefficient
            rd_addr = idx_in[ADDR_W-1:0];
            state_in = (idx_in == count_ff) ? S_DONE : S_LATCH;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = acc_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      point_ff     <= point_in;
      acc_ff       <= acc_in;
      pow_ff       <= pow_in;
      rsp_value_ff <= rsp_value_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         modulus_ff   <= DATA_W'(1);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   mpe_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_COEFS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_coefficient),
      .rd_addr (rd_addr),
      .rd_data (rd_coef)
   );

   // coef * point^idx mod m
   mpe_mulmod u_term_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (pow_ff),
      .b       (rd_coef),
      .modulus (modulus_ff),
      .result  (prod_term),
      .done    (term_done)
   );

   // point^idx * point mod m, finishes together with the term
   mpe_mulmod u_pow_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (pow_ff),
      .b       (point_ff),
      .modulus (modulus_ff),
      .result  (prod_pow),
      .done    (pow_done)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_poly_value = rsp_value_ff;

endmodule

// ===== sv/mpe_checker.sv =====
`include "assert_macros.svh"

module mpe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_type,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mpe_pkg::data_type rsp_poly_value,
   input logic              csr_write_enable,
   input mpe_pkg::data_type csr_write_data
);

   import mpe_pkg::*;

   // modulus as seen on the csr port
   data_type mod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= DATA_W'(1);
      end else if (csr_write_enable) begin
         mod_ff <= csr_write_data;
      end
   end

   logic load_fire;
   logic eval_fire;
   logic rsp_in_range;

   assign load_fire = req_valid && req_ready && (req_type == REQ_LOAD);
   assign eval_fire = req_valid && req_ready && (req_type == REQ_EVAL);
   assign rsp_in_range = ((mod_ff <= DATA_W'(1)) && (rsp_poly_value == '0))
                         || (rsp_poly_value < mod_ff);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_poly_value))
   `ASSERT_NEXT(a_load_one_cycle, clock, reset, load_fire, req_ready)
   `ASSERT_NEXT(a_eval_busy, clock, reset, eval_fire, !req_ready)
   `ASSERT_IMPLIES(a_rsp_range, clock, reset, rsp_valid, rsp_in_range)

endmodule

bind modular_polynomial_evaluator mpe_checker u_mpe_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// scoreboard: keeps its own coefficient table and modulus, works out the
// polynomial value for every accepted evaluate and checks responses in order
class poly_value_checker;
   mpe_pkg::data_type  coef_table [mpe_pkg::MAX_COEFS];
   mpe_pkg::count_type coef_total;
   mpe_pkg::data_type  modulus;
   mpe_pkg::data_type  pending_values [$];
   int unsigned        mismatches;

   function new();
      coef_total = '0;
      modulus    = 32'd1;
      mismatches = 0;
   endfunction

   function void set_modulus(mpe_pkg::data_type value);
      modulus = value;
   endfunction

   // exact modular evaluation, power of the point kept reduced
   function mpe_pkg::data_type poly_at(mpe_pkg::data_type x);
      logic [63:0] m;
      logic [63:0] acc;
      logic [63:0] pw;
      logic [63:0] xr;
      logic [63:0] term;
      m = {32'd0, modulus};
      if (m <= 64'd1) begin
         return '0;
      end
      acc = '0;
      pw  = 64'd1;
      xr  = {32'd0, x} % m;
      for (int j = 0; j < coef_total; j++) begin
         term = (({32'd0, coef_table[j]} % m) * pw) % m;
         acc  = (acc + term) % m;
         pw   = (pw * xr) % m;
      end
      return acc[31:0];
   endfunction

   function void note_request(logic kind, logic restart, mpe_pkg::data_type coef,
                              mpe_pkg::data_type pt);
      if (kind == mpe_pkg::REQ_LOAD) begin
         if (restart) begin
            coef_total = '0;
         end
         // a full table drops the load
         if (coef_total < mpe_pkg::MAX_COEFS) begin
            coef_table[coef_total[mpe_pkg::ADDR_W-1:0]] = coef;
            coef_total = coef_total + 1'b1;
         end
      end else begin
         pending_values.push_back(poly_at(pt));
      end
   endfunction

   function void check_value(mpe_pkg::data_type got);
      mpe_pkg::data_type want;
      if (pending_values.size() == 0) begin
         $display("%0t: poly_value expected none, actual %h", $time, got);
         mismatches++;
      end else begin
         want = pending_values.pop_front();
         if (got !== want) begin
            $display("%0t: poly_value expected %h, actual %h", $time, want, got);
            mismatches++;
         end
      end
   endfunction

   function int pending();
      return pending_values.size();
   endfunction
endclass

module tb;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_type;
   logic              req_restart_table;
   mpe_pkg::data_type req_coefficient;
   mpe_pkg::data_type req_point;
   logic              rsp_valid;
   logic              rsp_ready;
   mpe_pkg::data_type rsp_poly_value;
   logic              csr_write_enable;
   mpe_pkg::data_type csr_write_data;

   poly_value_checker board = new();

   // random idling on both sides, switched off for the last part
   bit          idling_on = 1'b1;
   // asks the response side for one long hold-off
   bit          long_hold = 1'b0;
   int unsigned sent_items = 0;
   int unsigned sent_evals = 0;

   modular_polynomial_evaluator DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_restart_table (req_restart_table),
      .req_coefficient   (req_coefficient),
      .req_point         (req_point),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_poly_value    (rsp_poly_value),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // guard against a hang, far beyond the slowest correct run
   initial begin
      #12_000_000;
      $display("tb NOT OK");
      $finish;
   end

   // sample both handshakes at the rising edge; responses first since a
   // response never belongs to the request taken at the same edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            board.check_value(rsp_poly_value);
         end
         if (req_valid && req_ready) begin
            board.note_request(req_type, req_restart_table, req_coefficient, req_point);
         end
      end
   end

   // response side: random stall bursts, plus one long hold-off on request
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (long_hold) begin
            // long enough that a finished value sits in the output register
            // and the next evaluate backs up into the request channel
            long_hold  = 1'b0;
            stall_left = 399;
            rsp_ready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // mix of full random words and values near the ends of the range
   function automatic mpe_pkg::data_type pick_word();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, 15);
         1:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic mpe_pkg::data_type pick_modulus();
      case ($urandom_range(0, 7))
         0:       return 32'd1;
         1:       return 32'd2;
         2:       return 32'hFFFF_FFFF;
         3:       return $urandom_range(3, 1000);
         4:       return 32'h8000_0000 | $urandom;
         5:       return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_request(logic kind, logic restart, mpe_pkg::data_type coef,
                               mpe_pkg::data_type pt);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_restart_table <= restart;
      req_coefficient   <= coef;
      req_point         <= pt;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      sent_items++;
      if (kind == mpe_pkg::REQ_EVAL) begin
         sent_evals++;
      end
   endtask

   task automatic load_coef(logic restart, mpe_pkg::data_type coef);
      // the point is unused on a load, so it carries noise
      send_request(mpe_pkg::REQ_LOAD, restart, coef, $urandom);
   endtask

   task automatic eval_at(mpe_pkg::data_type pt);
      // restart and coefficient are unused on an evaluate
      send_request(mpe_pkg::REQ_EVAL, 1'($urandom_range(0, 1)), $urandom, pt);
   endtask

   // drop valid, let every expected value come back, then let a trailing
   // load settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_modulus(mpe_pkg::data_type value);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_modulus(value);
   endtask

   initial begin
      int unsigned n_loads;
      int unsigned n_evals;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_type          = mpe_pkg::REQ_LOAD;
      req_restart_table = 1'b0;
      req_coefficient   = '0;
      req_point         = '0;
      csr_write_enable  = 1'b0;
      csr_write_data    = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // empty table under the reset modulus of one
      eval_at(32'hFFFF_FFFF);
      // empty table with a real modulus
      write_modulus(32'hFFFF_FFFF);
      eval_at(32'h1234_5678);
      // restart on the very first load, then extremes of coefficient and point
      load_coef(1'b1, 32'hFFFF_FFFF);
      eval_at(32'hFFFF_FFFF);
      load_coef(1'b0, 32'h0000_0000);
      load_coef(1'b0, 32'hFFFF_FFFE);
      eval_at(32'h0000_0000);
      eval_at(32'h0000_0001);
      eval_at(32'hFFFF_FFFF);
      // smallest useful modulus
      write_modulus(32'd2);
      eval_at(32'hFFFF_FFFF);
      load_coef(1'b1, 32'hFFFF_FFFE);
      eval_at(32'h8000_0000);
      // modulus of zero behaves like one
      write_modulus(32'd0);
      eval_at(32'h7FFF_FFFF);
      // power of two modulus, alternating bit patterns
      write_modulus(32'h8000_0000);
      load_coef(1'b1, 32'hAAAA_AAAA);
      load_coef(1'b0, 32'h5555_5555);
      load_coef(1'b0, 32'h7FFF_FFFF);
      eval_at(32'h5555_5555);
      eval_at(32'hAAAA_AAAA);
      // modulus of one with a non-empty table
      write_modulus(32'd1);
      eval_at(32'hFFFF_FFFF);

      // ---- random part ----
      write_modulus(32'hFFFF_FFFB);
      // back-pressure: response side holds off while evaluates keep coming
      long_hold = 1'b1;
      load_coef(1'b1, pick_word());
      load_coef(1'b0, pick_word());
      load_coef(1'b0, pick_word());
      repeat (6) eval_at(pick_word());

      while (sent_items < 80 || sent_evals < 30) begin
         if ($urandom_range(0, 3) == 0) begin
            write_modulus(pick_modulus());
         end
         if ($urandom_range(0, 5) == 0) begin
            // noise: any request type with any fields
            send_request(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_word(),
                         pick_word());
         end else begin
            // a fresh table (now and then an append or a restart midway)
            n_loads = $urandom_range(1, 8);
            n_evals = $urandom_range(1, 3);
            load_coef($urandom_range(0, 4) != 0, pick_word());
            for (int k = 1; k < n_loads; k++) begin
               load_coef($urandom_range(0, 9) == 0, pick_word());
            end
            repeat (n_evals) eval_at(pick_word());
         end
      end

      // ---- last part, no idling: requests back to back ----
      idling_on = 1'b0;
      write_modulus(32'hFFFF_FFFB);
      load_coef(1'b1, pick_word());
      repeat (4) load_coef(1'b0, pick_word());
      repeat (3) eval_at(pick_word());

      wait_idle();
      repeat (100) @(negedge clock);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
